### sv/ssdl_pkg.sv
// shared types, constants and the character to segment table for the
// seven-segment display link sender; no dependencies
package ssdl_pkg;

  localparam int unsigned DIGIT_COUNT_DEF = 4;
  localparam int unsigned CHAR_COUNT      = 4;
  localparam int unsigned PHASE_W         = 5;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 8;
  localparam int unsigned QUEUE_DEPTH     = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_ON = 1'b1;

  // item kinds
  localparam logic REQ_DISPLAY = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  localparam logic [7:0] CMD_DATA  = 8'h40;
  localparam logic [7:0] CMD_ADDR  = 8'hC0;
  localparam logic [7:0] CMD_CTRL  = 8'h80;
  localparam logic [7:0] SEG_BLANK = 8'h00;

  // line phases of one byte: eight bits of three phases, then the ack slot
  localparam logic [PHASE_W-1:0] PH_BITS_END = 5'd24;
  localparam logic [PHASE_W-1:0] PH_ACK_REL  = 5'd25;
  localparam logic [PHASE_W-1:0] PH_ACK_HI   = 5'd26;
  localparam logic [PHASE_W-1:0] PH_ACK_LO   = 5'd27;
  localparam logic [PHASE_W-1:0] PH_BYTE_END = 5'd28;
  localparam logic [PHASE_W-1:0] PH_EDGE_END = 5'd3;

  typedef struct packed {
    logic                            req_type;
    logic [CHAR_COUNT-1:0][7:0]      segs;
  } ssdl_item_t;

  typedef struct packed {
    logic       valid;
    ssdl_item_t item;
  } ssdl_q_t;

  typedef struct packed {
    logic clk_level;
    logic dio_level;
    logic dio_released;
    logic busy;
    logic accepted;
    logic done;
  } ssdl_res_t;

  function automatic logic [7:0] char_to_seg(logic [7:0] c);
    logic [7:0] s;
    unique case (c)
      8'h30: s = 8'h3F;  8'h31: s = 8'h06;
      8'h32: s = 8'h5B;  8'h33: s = 8'h4F;
      8'h34: s = 8'h66;  8'h35: s = 8'h6D;
      8'h36: s = 8'h7D;  8'h37: s = 8'h07;
      8'h38: s = 8'h7F;  8'h39: s = 8'h6F;
      8'h41: s = 8'h77;  8'h42: s = 8'h7C;
      8'h43: s = 8'h39;  8'h44: s = 8'h5E;
      8'h45: s = 8'h79;  8'h46: s = 8'h71;
      8'h47: s = 8'h3D;  8'h48: s = 8'h76;
      8'h49: s = 8'h30;  8'h4C: s = 8'h38;
      8'h4E: s = 8'h54;  8'h4F: s = 8'h3F;
      8'h50: s = 8'h73;  8'h52: s = 8'h50;
      8'h53: s = 8'h6D;  8'h54: s = 8'h78;
      8'h55: s = 8'h3E;  8'h59: s = 8'h6E;
      8'h2D: s = 8'h40;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

### sv/ssdl_front.sv
// front end: takes items, maps characters to segment bytes and queues them
// depends on ssdl_pkg
module ssdl_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [7:0]         char_0_i,
  input  logic [7:0]         char_1_i,
  input  logic [7:0]         char_2_i,
  input  logic [7:0]         char_3_i,
  output ssdl_pkg::ssdl_q_t  q_o,
  input  logic               pop_i
);

  localparam int unsigned PTR_W = $clog2(ssdl_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(ssdl_pkg::QUEUE_DEPTH + 1);

  ssdl_pkg::ssdl_item_t entry_q [ssdl_pkg::QUEUE_DEPTH];
  ssdl_pkg::ssdl_item_t item_in;
  logic [PTR_W-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 push, pop;

  always_comb begin
    item_in.req_type = req_type_i;
    item_in.segs[0]  = ssdl_pkg::char_to_seg(char_0_i);
    item_in.segs[1]  = ssdl_pkg::char_to_seg(char_1_i);
    item_in.segs[2]  = ssdl_pkg::char_to_seg(char_2_i);
    item_in.segs[3]  = ssdl_pkg::char_to_seg(char_3_i);
  end

  assign in_ready_o = (cnt_q != CNT_W'(ssdl_pkg::QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (cnt_q != '0);

  assign q_o.valid = (cnt_q != '0);
  assign q_o.item  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(ssdl_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(ssdl_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

### sv/ssdl_back.sv
// back end: segment store, frame sequencer driving the line phases, config
// registers and the result register; depends on ssdl_pkg
module ssdl_back #(
  parameter int unsigned DIGIT_COUNT = ssdl_pkg::DIGIT_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ssdl_pkg::ssdl_q_t               q_i,
  output logic                            pop_o,
  input  logic                            cfg_we_i,
  input  logic [ssdl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ssdl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ssdl_pkg::ssdl_res_t             res_o
);

  localparam int unsigned LAST_E = DIGIT_COUNT + 8;
  localparam int unsigned ELEM_W = $clog2(LAST_E + 1);
  localparam int unsigned SEG_W  = $clog2(DIGIT_COUNT);
  localparam int unsigned PW     = ssdl_pkg::PHASE_W;

  // element order: start, data cmd, stop, start, address, digits, stop,
  // start, control, stop
  localparam logic [ELEM_W-1:0] E_CMD_DATA  = ELEM_W'(1);
  localparam logic [ELEM_W-1:0] E_STOP_0    = ELEM_W'(2);
  localparam logic [ELEM_W-1:0] E_START_1   = ELEM_W'(3);
  localparam logic [ELEM_W-1:0] E_CMD_ADDR  = ELEM_W'(4);
  localparam logic [ELEM_W-1:0] E_DIGIT_0   = ELEM_W'(5);
  localparam logic [ELEM_W-1:0] E_STOP_1    = ELEM_W'(DIGIT_COUNT + 5);
  localparam logic [ELEM_W-1:0] E_START_2   = ELEM_W'(DIGIT_COUNT + 6);
  localparam logic [ELEM_W-1:0] E_LAST      = ELEM_W'(LAST_E);

  logic [7:0]        seg_q [DIGIT_COUNT];
  logic [2:0]        brightness_q;
  logic              display_on_q;
  logic              active_q, active_d;
  logic [ELEM_W-1:0] elem_q, elem_d, elem_off;
  logic [PW-1:0]     phase_q, phase_d;
  logic [1:0]        sub_q, sub_d;
  logic [7:0]        shift_q, shift_d, byte_sel;
  logic              clk_q, clk_d, dio_q, dio_d, rel_q, rel_d;
  logic              out_valid_q, out_valid_d;
  ssdl_pkg::ssdl_res_t res_q, res_d;
  logic              take, load, is_start, is_stop, last_phase, accepted, done;
  logic [SEG_W-1:0]  seg_idx;

  assign take  = q_i.valid && (!out_valid_q || out_ready_i);
  assign pop_o = take;
  assign load  = take && (q_i.item.req_type == ssdl_pkg::REQ_DISPLAY) && !active_q;

  assign is_start = (elem_q == '0) || (elem_q == E_START_1) || (elem_q == E_START_2);
  assign is_stop  = (elem_q == E_STOP_0) || (elem_q == E_STOP_1) || (elem_q == E_LAST);
  assign elem_off = elem_q - E_DIGIT_0;
  assign seg_idx  = elem_off[SEG_W-1:0];

  always_comb begin
    if (elem_q == E_CMD_DATA) begin
      byte_sel = ssdl_pkg::CMD_DATA;
    end else if (elem_q == E_CMD_ADDR) begin
      byte_sel = ssdl_pkg::CMD_ADDR;
    end else if (elem_q >= E_DIGIT_0 && elem_q < E_STOP_1) begin
      byte_sel = seg_q[seg_idx];
    end else begin
      byte_sel = ssdl_pkg::CMD_CTRL | {4'b0000, display_on_q, brightness_q};
    end
  end

  always_comb begin
    active_d   = active_q;
    elem_d     = elem_q;
    phase_d    = phase_q;
    sub_d      = sub_q;
    shift_d    = shift_q;
    clk_d      = clk_q;
    dio_d      = dio_q;
    rel_d      = rel_q;
    accepted   = 1'b0;
    done       = 1'b0;
    last_phase = 1'b0;
    if (load) begin
      active_d = 1'b1;
      elem_d   = '0;
      phase_d  = '0;
      sub_d    = '0;
      accepted = 1'b1;
    end else if (take && q_i.item.req_type == ssdl_pkg::REQ_TICK && active_q) begin
      if (is_start) begin
        case (phase_q[1:0])
          2'd0:    dio_d = 1'b1;
          2'd1:    clk_d = 1'b1;
          2'd2:    dio_d = 1'b0;
          default: clk_d = 1'b0;
        endcase
        last_phase = (phase_q == ssdl_pkg::PH_EDGE_END);
      end else if (is_stop) begin
        case (phase_q[1:0])
          2'd0:    clk_d = 1'b0;
          2'd1:    dio_d = 1'b0;
          2'd2:    clk_d = 1'b1;
          default: dio_d = 1'b1;
        endcase
        last_phase = (phase_q == ssdl_pkg::PH_EDGE_END);
      end else begin
        if (phase_q < ssdl_pkg::PH_BITS_END) begin
          case (sub_q)
            2'd0: begin
              clk_d = 1'b0;
              if (phase_q == '0) begin
                shift_d = byte_sel;
              end
            end
            2'd1:    dio_d = shift_q[0];
            default: begin
              clk_d   = 1'b1;
              shift_d = {1'b0, shift_q[7:1]};
            end
          endcase
        end else if (phase_q == ssdl_pkg::PH_ACK_REL) begin
          rel_d = 1'b1;
        end else if (phase_q == ssdl_pkg::PH_ACK_HI) begin
          clk_d = 1'b1;
        end else if (phase_q == ssdl_pkg::PH_BYTE_END) begin
          rel_d = 1'b0;
        end else begin
          // first and last clock-low phases of the ack slot
          clk_d = 1'b0;
        end
        last_phase = (phase_q == ssdl_pkg::PH_BYTE_END);
      end
      sub_d = (sub_q == 2'd2) ? 2'd0 : sub_q + 1'b1;
      if (last_phase) begin
        phase_d = '0;
        sub_d   = '0;
        if (elem_q == E_LAST) begin
          elem_d   = '0;
          active_d = 1'b0;
          done     = 1'b1;
        end else begin
          elem_d = elem_q + 1'b1;
        end
      end else begin
        phase_d = phase_q + 1'b1;
      end
    end
  end

  always_comb begin
    res_d              = res_q;
    out_valid_d        = out_valid_q;
    if (take) begin
      out_valid_d        = 1'b1;
      res_d.clk_level    = clk_d;
      res_d.dio_level    = dio_d;
      res_d.dio_released = rel_d;
      res_d.busy         = active_d;
      res_d.accepted     = accepted;
      res_d.done         = done;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      elem_q       <= '0;
      phase_q      <= '0;
      sub_q        <= '0;
      shift_q      <= '0;
      clk_q        <= 1'b1;
      dio_q        <= 1'b1;
      rel_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      brightness_q <= 3'd2;
      display_on_q <= 1'b1;
    end else begin
      active_q    <= active_d;
      elem_q      <= elem_d;
      phase_q     <= phase_d;
      sub_q       <= sub_d;
      shift_q     <= shift_d;
      clk_q       <= clk_d;
      dio_q       <= dio_d;
      rel_q       <= rel_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          ssdl_pkg::CFG_BRIGHTNESS: brightness_q <= cfg_data_i[2:0];
          ssdl_pkg::CFG_DISPLAY_ON: display_on_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // digits past the fourth character are blank
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        seg_q[i] <= (i < ssdl_pkg::CHAR_COUNT) ?
                    q_i.item.segs[i % ssdl_pkg::CHAR_COUNT] : ssdl_pkg::SEG_BLANK;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

### sv/seven_segment_display_link_sender.sv
// top level of the seven-segment display link sender
// depends on ssdl_pkg, ssdl_front and ssdl_back
//
// Input channel (in_valid_i/in_ready_o): each item is either a display
// request with four ASCII characters (req_type_i = 0) or one line tick
// (req_type_i = 1). A request starts the three-frame sequence if the block is
// idle and is otherwise dropped; while busy every tick moves the two lines by
// one phase, and a tick while idle changes nothing.
// Each input item gives exactly one result on the output channel
// (out_valid_o/out_ready_i): line levels after the item, busy, whether a
// request was taken, and a done flag on the tick that ends the last stop.
// An accepted input passes the queue, then the result register. One item per
// cycle is sustained while results are taken, one sequencer step per item.
// A two-entry queue between front and back plus the result register lets the
// input side keep going for up to three items while the receiver stalls;
// after that in_ready_o drops until a result is taken.
// Config port (cfg_valid_i/cfg_ready_o): always ready, index 0 brightness,
// index 1 display enable. Reset: lines idle high, not busy, brightness 2,
// display on, queue empty.
module seven_segment_display_link_sender #(
  parameter int unsigned DIGIT_COUNT = ssdl_pkg::DIGIT_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            req_type_i,
  input  logic [7:0]                      char_0_i,
  input  logic [7:0]                      char_1_i,
  input  logic [7:0]                      char_2_i,
  input  logic [7:0]                      char_3_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            clk_level_o,
  output logic                            dio_level_o,
  output logic                            dio_released_o,
  output logic                            busy_res_o,
  output logic                            request_accepted_o,
  output logic                            sequence_done_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ssdl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ssdl_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  ssdl_pkg::ssdl_q_t   q;
  ssdl_pkg::ssdl_res_t res;
  logic                pop;

  assign cfg_ready_o = 1'b1;

  ssdl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .char_0_i   (char_0_i),
    .char_1_i   (char_1_i),
    .char_2_i   (char_2_i),
    .char_3_i   (char_3_i),
    .q_o        (q),
    .pop_i      (pop)
  );

  ssdl_back #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_i         (q),
    .pop_o       (pop),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign clk_level_o        = res.clk_level;
  assign dio_level_o        = res.dio_level;
  assign dio_released_o     = res.dio_released;
  assign busy_res_o         = res.busy;
  assign request_accepted_o = res.accepted;
  assign sequence_done_o    = res.done;

endmodule

### sim/testbench.sv
// self-checking bench for seven_segment_display_link_sender: random display requests and line
// ticks against a line-phase tracker kept in a small scoreboard class
// depends on ssdl_pkg and the block's top level
`timescale 1ns / 1ps

import ssdl_pkg::*;

typedef enum int unsigned {LINK_START, LINK_BYTE, LINK_STOP} link_elem_e;

class link_tracker;
  logic [2:0]  brightness;
  logic        display_on;
  logic [7:0]  glyphs [CHAR_COUNT];
  int unsigned phase;
  int unsigned elem;
  logic [7:0]  shift;
  logic        lclk, ldio, lrel, active;
  ssdl_res_t   line_levels_q [$];
  int unsigned mismatches;

  function new();
    brightness = 3'd2;
    display_on = 1'b1;
    foreach (glyphs[i]) glyphs[i] = SEG_BLANK;
    phase = 0;
    elem = 0;
    shift = 8'h00;
    lclk = 1'b1;
    ldio = 1'b1;
    lrel = 1'b0;
    active = 1'b0;
    mismatches = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_BRIGHTNESS) brightness = data[2:0];
    else display_on = data[0];
  endfunction

  function logic [7:0] glyph_of(logic [7:0] c);
    case (c)
      "0": return 8'h3F; "1": return 8'h06; "2": return 8'h5B; "3": return 8'h4F;
      "4": return 8'h66; "5": return 8'h6D; "6": return 8'h7D; "7": return 8'h07;
      "8": return 8'h7F; "9": return 8'h6F; "A": return 8'h77; "B": return 8'h7C;
      "C": return 8'h39; "D": return 8'h5E; "E": return 8'h79; "F": return 8'h71;
      "G": return 8'h3D; "H": return 8'h76; "I": return 8'h30; "L": return 8'h38;
      "N": return 8'h54; "O": return 8'h3F; "P": return 8'h73; "R": return 8'h50;
      "S": return 8'h6D; "T": return 8'h78; "U": return 8'h3E; "Y": return 8'h6E;
      "-": return 8'h40;
      default: return SEG_BLANK;
    endcase
  endfunction

  // frame layout: start, data cmd, stop, start, addr, digits, stop, start, ctrl, stop
  function link_elem_e kind_of(int unsigned e);
    if (e == 0 || e == 3 || e == DIGIT_COUNT_DEF + 6) return LINK_START;
    if (e == 2 || e == DIGIT_COUNT_DEF + 5 || e == DIGIT_COUNT_DEF + 8) return LINK_STOP;
    return LINK_BYTE;
  endfunction

  function logic [7:0] byte_of(int unsigned e);
    if (e == 1) return CMD_DATA;
    if (e == 4) return CMD_ADDR;
    if (e >= 5 && e < 5 + DIGIT_COUNT_DEF) begin
      if (e - 5 < CHAR_COUNT) return glyphs[e-5];
      return SEG_BLANK;
    end
    return CMD_CTRL | {4'b0000, display_on, brightness};
  endfunction

  // one line phase; returns 1 when the final stop has completed
  function bit advance();
    int unsigned last;
    last = 32'(PH_EDGE_END);
    case (kind_of(elem))
      LINK_START: begin
        case (phase)
          0: ldio = 1'b1;
          1: lclk = 1'b1;
          2: ldio = 1'b0;
          default: lclk = 1'b0;
        endcase
      end
      LINK_STOP: begin
        case (phase)
          0: lclk = 1'b0;
          1: ldio = 1'b0;
          2: lclk = 1'b1;
          default: ldio = 1'b1;
        endcase
      end
      default: begin
        last = 32'(PH_BYTE_END);
        if (phase < PH_BITS_END) begin
          if (phase == 0) shift = byte_of(elem);
          case (phase % 3)
            0: lclk = 1'b0;
            1: ldio = shift[0];
            default: begin
              lclk = 1'b1;
              shift = shift >> 1;
            end
          endcase
        end else if (phase == PH_BITS_END) begin
          lclk = 1'b0;
        end else if (phase == PH_ACK_REL) begin
          lrel = 1'b1;
        end else if (phase == PH_ACK_HI) begin
          lclk = 1'b1;
        end else if (phase == PH_ACK_LO) begin
          lclk = 1'b0;
        end else begin
          lrel = 1'b0;
        end
      end
    endcase
    if (phase == last) begin
      phase = 0;
      if (elem >= DIGIT_COUNT_DEF + 8) begin
        elem = 0;
        return 1'b1;
      end
      elem = elem + 1;
    end else begin
      phase = phase + 1;
    end
    return 1'b0;
  endfunction

  function void take_item(logic rt, logic [3:0][7:0] chars);
    ssdl_res_t r;
    bit taken, finished;
    taken = 1'b0;
    finished = 1'b0;
    if (rt == REQ_DISPLAY) begin
      if (!active) begin
        for (int i = 0; i < CHAR_COUNT; i++) glyphs[i] = glyph_of(chars[i]);
        active = 1'b1;
        elem = 0;
        phase = 0;
        taken = 1'b1;
      end
    end else if (active) begin
      finished = advance();
      if (finished) active = 1'b0;
    end
    r.clk_level    = lclk;
    r.dio_level    = ldio;
    r.dio_released = lrel;
    r.busy         = active;
    r.accepted     = taken;
    r.done         = finished;
    line_levels_q.push_back(r);
  endfunction

  function void check_levels(ssdl_res_t got);
    ssdl_res_t exp;
    if (line_levels_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result with nothing expected: %b", got);
      return;
    end
    exp = line_levels_q.pop_front();
    if (got.clk_level !== exp.clk_level || got.dio_level !== exp.dio_level ||
        got.dio_released !== exp.dio_released || got.busy !== exp.busy ||
        got.accepted !== exp.accepted || got.done !== exp.done) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch clk/dio/rel/busy/acc/done: expected %b%b%b%b%b%b actual %b%b%b%b%b%b",
                 exp.clk_level, exp.dio_level, exp.dio_released, exp.busy, exp.accepted,
                 exp.done, got.clk_level, got.dio_level, got.dio_released, got.busy,
                 got.accepted, got.done);
    end
  endfunction

  function int unsigned pending();
    return line_levels_q.size();
  endfunction
endclass

module testbench;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic req_type = REQ_TICK;
  logic [7:0] char_0 = 8'h00, char_1 = 8'h00, char_2 = 8'h00, char_3 = 8'h00;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BRIGHTNESS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic in_ready, out_valid, cfg_ready;
  logic clk_level, dio_level, dio_released, busy_res, request_accepted, sequence_done;

  link_tracker sb;
  int unsigned counted = 0;
  logic quiet;
  string known_chars = "0123456789ABCDEFGHILNOPRSTUY-";

  // no idling on either side over a stretch of the run
  assign quiet = (counted >= 400 && counted < 700);

  seven_segment_display_link_sender u_top (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .req_type_i         (req_type),
    .char_0_i           (char_0),
    .char_1_i           (char_1),
    .char_2_i           (char_2),
    .char_3_i           (char_3),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .clk_level_o        (clk_level),
    .dio_level_o        (dio_level),
    .dio_released_o     (dio_released),
    .busy_res_o         (busy_res),
    .request_accepted_o (request_accepted),
    .sequence_done_o    (sequence_done),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= quiet || ($urandom_range(0, 99) >= 10);
  end

  always @(posedge clk) begin
    ssdl_res_t got;
    if (rst_n && out_valid && out_ready) begin
      got.clk_level    = clk_level;
      got.dio_level    = dio_level;
      got.dio_released = dio_released;
      got.busy         = busy_res;
      got.accepted     = request_accepted;
      got.done         = sequence_done;
      sb.check_levels(got);
    end
  end

  task automatic send_item(input logic rt, input logic [3:0][7:0] chars);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    char_0   <= chars[0];
    char_1   <= chars[1];
    char_2   <= chars[2];
    char_3   <= chars[3];
    do @(posedge clk); while (!in_ready);
    sb.take_item(rt, chars);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for every result, then wait on for the pipeline to settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r <= 5) return known_chars[$urandom_range(0, known_chars.len() - 1)];
    if (r == 6) return " ";
    if (r == 7) return 8'(8'h61 + $urandom_range(0, 25));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_item();
    logic [3:0][7:0] chars;
    logic rt;
    bit was_busy;
    for (int i = 0; i < 4; i++) chars[i] = pick_char();
    was_busy = sb.active;
    // mostly ticks while a sequence runs, mostly requests while idle
    if (was_busy) rt = ($urandom_range(0, 99) < 95) ? REQ_TICK : REQ_DISPLAY;
    else rt = ($urandom_range(0, 99) < 85) ? REQ_DISPLAY : REQ_TICK;
    send_item(rt, chars);
    if ((rt == REQ_TICK) == was_busy) counted++;
  endtask

  initial begin
    int unsigned chunk;
    logic [CFG_DATA_W-1:0] value;
    sb = new();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // extremes of both registers, upper data bits set
    write_reg(CFG_BRIGHTNESS, 8'hFF);
    write_reg(CFG_DISPLAY_ON, 8'hFE);

    send_item(REQ_TICK, {8'h00, 8'h00, 8'h00, 8'h00});   // tick while idle
    send_item(REQ_DISPLAY, {" ", "-", 8'hFF, 8'h00});    // char_0 = 0x00 leftmost
    repeat (6) send_item(REQ_TICK, {8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_item(REQ_DISPLAY, {"8", "8", "8", "8"});         // request while busy
    repeat (14) send_item(REQ_TICK, {8'h00, 8'h00, 8'h00, 8'h00});
    drain();
    // change of control byte mid-sequence, before it starts shifting
    write_reg(CFG_BRIGHTNESS, 8'h00);
    write_reg(CFG_DISPLAY_ON, 8'h01);

    chunk = 0;
    while (counted < 1200) begin
      repeat ($urandom_range(30, 150)) random_item();
      drain();
      chunk++;
      if ($urandom_range(0, 1) == 1) begin
        value = CFG_DATA_W'($urandom_range(0, 255));
        if (chunk % 3 == 0) value[2:0] = 3'd0;
        else if (chunk % 3 == 1) value[2:0] = 3'd7;
        write_reg(CFG_BRIGHTNESS, value);
        write_reg(CFG_DISPLAY_ON, CFG_DATA_W'($urandom_range(0, 255)));
      end
    end

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS seven_segment_display_link_sender");
    end else begin
      $display("FAIL seven_segment_display_link_sender");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL seven_segment_display_link_sender");
    $finish;
  end

endmodule
